### rtl/core/hex_tile_color_index_assert.svh
// Assertion macros for the hex tile color index block.
// Included by files that check their own logic; no other dependencies.
`ifndef HEX_TILE_COLOR_INDEX_ASSERT_SVH
`define HEX_TILE_COLOR_INDEX_ASSERT_SVH
`ifndef SYNTHESIS
`define HTCI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("htci check failed");
`define HTCI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("htci check failed");
`else
`define HTCI_ASSERT_SAME(label, clk, rst, ante, cons)
`define HTCI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/htci_pkg.sv
// Shared types, constants and the rounding function of the hex tile color index block.
// No dependencies.
`timescale 1ns / 1ps
package htci_pkg;
   localparam int XY_W = 32;
   localparam int CELL_W = 16;
   localparam int COLOR_W = 8;
   localparam int LEVEL_W = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_SIZE = 1'b1;

   localparam logic [CELL_W-1:0] CELL_SIZE_RESET = 16'd32;
   localparam logic [COLOR_W-1:0] PALETTE_SIZE_RESET = 8'd3;
   localparam logic [COLOR_W-1:0] MIN_COLORS = 8'd3;

   localparam logic signed [47:0] K_QX = 48'sd43691;
   localparam logic signed [47:0] K_RY = 48'sd37837;
   localparam logic signed [47:0] K_RX = 48'sd21845;
   localparam logic [15:0] HALF = 16'd32768;

   typedef struct packed {
      logic signed [17:0] rnd;
      logic [16:0] err;
   } round_type;

   // round half toward positive infinity on Q16 value, with the exact rounding error
   function automatic round_type htci_round(input logic signed [31:0] v);
      logic neg;
      logic [31:0] m;
      logic [15:0] low;
      logic up;
      logic [16:0] mg;
      round_type res;
      neg = v[31];
      m = neg ? 32'(-v) : 32'(v);
      low = m[15:0];
      up = neg ? (low > HALF) : (low >= HALF);
      mg = {1'b0, m[31:16]} + 17'(up);
      res.rnd = neg ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
      res.err = up ? 17'(17'h10000 - {1'b0, low}) : {1'b0, low};
      return res;
   endfunction
endpackage

### rtl/core/htci_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on htci_pkg.
`timescale 1ns / 1ps
interface htci_req_if;
   logic valid;
   logic ready;
   logic signed [htci_pkg::XY_W-1:0] x_coord;
   logic signed [htci_pkg::XY_W-1:0] y_coord;
   modport source (output valid, x_coord, y_coord, input ready);
   modport sink (input valid, x_coord, y_coord, output ready);
endinterface

interface htci_rsp_if;
   logic valid;
   logic ready;
   logic [htci_pkg::LEVEL_W-1:0] level;
   modport source (output valid, level, input ready);
   modport sink (input valid, level, output ready);
endinterface

### rtl/core/htci_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// No dependencies.
`timescale 1ns / 1ps
module htci_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 16,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  quo,
   output logic [DEN_W-1:0]  rem,
   output logic [SIDE_W-1:0] side_out
);
   localparam int STAGES = NUM_W + 1;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [DEN_W-1:0]  rem_ff [STAGES];
   logic [DEN_W-1:0]  rem_in [STAGES];
   logic [NUM_W-1:0]  work_ff [STAGES];
   logic [NUM_W-1:0]  work_in [STAGES];
   logic [DEN_W-1:0]  den_ff [STAGES];
   logic [DEN_W-1:0]  den_in [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];
   logic [SIDE_W-1:0] side_in [STAGES];
   logic [DEN_W:0]    cat [STAGES];
   logic              qb [STAGES];

   always_comb begin
      valid_in[0] = in_valid;
      rem_in[0] = '0;
      work_in[0] = num;
      den_in[0] = den;
      side_in[0] = side;
      cat[STAGES-1] = '0;
      qb[STAGES-1] = 1'b0;
      for (int k = 0; k < STAGES - 1; k++) begin
         cat[k] = {rem_ff[k], work_ff[k][NUM_W-1]};
         qb[k] = cat[k] >= {1'b0, den_ff[k]};
         rem_in[k+1] = qb[k] ? DEN_W'(cat[k] - {1'b0, den_ff[k]}) : cat[k][DEN_W-1:0];
         work_in[k+1] = {work_ff[k][NUM_W-2:0], qb[k]};
         valid_in[k+1] = valid_ff[k];
         den_in[k+1] = den_ff[k];
         side_in[k+1] = side_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            work_ff[k] <= work_in[k];
            den_ff[k] <= den_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign quo = work_ff[STAGES-1];
   assign rem = rem_ff[STAGES-1];
   assign side_out = side_ff[STAGES-1];
endmodule

### rtl/core/hex_tile_color_index.sv
// Top level of the hex tile color index block: flat-top hex cube rounding to a level.
// Depends on htci_pkg, htci_if, htci_div and hex_tile_color_index_assert.svh.
//
//  channel | dir | handshake        | payload
//  req     | in  | valid/ready      | x_coord, y_coord (signed Q32.0)
//  rsp     | out | valid/ready      | level (16 bit)
//  csr     | in  | csr_we only      | csr_index, csr_wdata
//
// One transaction enters per clock unless the output stalls; most stages lie in the
// three bit-per-stage dividers (48 + 18 + 24 quotient bits plus input registers).
// The whole pipeline advances together whenever the output register is empty or
// being taken; a stalled response freezes every stage, so nothing is lost or repeated.
// Synchronous reset clears valid bits and restores cell size 32 and three colors.
`timescale 1ns / 1ps
`include "hex_tile_color_index_assert.svh"
module hex_tile_color_index (
   input logic clock,
   input logic reset,
   htci_req_if.sink   req_chan,
   htci_rsp_if.source rsp_chan,
   input logic                               csr_we,
   input logic [htci_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [htci_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import htci_pkg::*;

   // configuration
   logic [CELL_W-1:0]  cell_size_ff;
   logic [COLOR_W-1:0] palette_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= CELL_SIZE_RESET;
         palette_size_ff <= PALETTE_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CELL_SIZE:    cell_size_ff <= csr_wdata;
            CSR_PALETTE_SIZE: palette_size_ff <= csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // global advance: output register empty or draining
   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // stage 1: capture, clamp color count
   logic v1_ff;
   logic signed [XY_W-1:0] x1_ff, y1_ff;
   logic [CELL_W-1:0] cs1_ff;
   logic [COLOR_W-1:0] col1_ff;
   logic zero1_ff;

   // stage 2: products
   logic v2_ff;
   logic signed [47:0] pq2_ff, py2_ff, px2_ff;
   logic [CELL_W-1:0] cs2_ff;
   logic [COLOR_W-1:0] col2_ff;
   logic zero2_ff;

   // stage 3: r numerator, magnitudes and signs
   logic v3_ff;
   logic [47:0] mq3_ff, mr3_ff;
   logic sq3_ff, sr3_ff;
   logic [CELL_W-1:0] cs3_ff;
   logic [COLOR_W-1:0] col3_ff;
   logic zero3_ff;
   logic signed [48:0] rn2;
   logic signed [48:0] qn2;

   assign qn2 = 49'(pq2_ff);
   assign rn2 = 49'(py2_ff) - 49'(px2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= req_chan.x_coord;
         y1_ff <= req_chan.y_coord;
         cs1_ff <= cell_size_ff;
         col1_ff <= (palette_size_ff < MIN_COLORS) ? MIN_COLORS : palette_size_ff;
         zero1_ff <= (cell_size_ff == '0);
         pq2_ff <= 48'(x1_ff) * K_QX;
         py2_ff <= 48'(y1_ff) * K_RY;
         px2_ff <= 48'(x1_ff) * K_RX;
         cs2_ff <= cs1_ff;
         col2_ff <= col1_ff;
         zero2_ff <= zero1_ff;
         sq3_ff <= qn2[48];
         sr3_ff <= rn2[48];
         mq3_ff <= qn2[48] ? 48'(-qn2) : 48'(qn2);
         mr3_ff <= rn2[48] ? 48'(-rn2) : 48'(rn2);
         cs3_ff <= cs2_ff;
         col3_ff <= col2_ff;
         zero3_ff <= zero2_ff;
      end
   end

   // axial q and r quotients, truncated toward zero
   logic vq_out, vr_out;
   logic [47:0] quo_q, quo_r;
   logic [COLOR_W+1:0] side_q;
   logic side_r;

   htci_div #(.NUM_W(48), .DEN_W(CELL_W), .SIDE_W(COLOR_W + 2)) u_div_q (
      .clock(clock), .reset(reset), .en(en), .in_valid(v3_ff),
      .num(mq3_ff), .den(cs3_ff), .side({sq3_ff, zero3_ff, col3_ff}),
      .out_valid(vq_out), .quo(quo_q), .rem(), .side_out(side_q)
   );

   htci_div #(.NUM_W(48), .DEN_W(CELL_W), .SIDE_W(1)) u_div_r (
      .clock(clock), .reset(reset), .en(en), .in_valid(v3_ff),
      .num(mr3_ff), .den(cs3_ff), .side(sr3_ff),
      .out_valid(vr_out), .quo(quo_r), .rem(), .side_out(side_r)
   );

   // stage 4: signed wrap of q, r and s = -q - r
   logic v4_ff, zero4_ff;
   logic [COLOR_W-1:0] col4_ff;
   logic signed [31:0] q4_ff, r4_ff, s4_ff;
   logic signed [31:0] q_w, r_w;

   assign q_w = side_q[COLOR_W+1] ? -$signed(quo_q[31:0]) : $signed(quo_q[31:0]);
   assign r_w = side_r ? -$signed(quo_r[31:0]) : $signed(quo_r[31:0]);

   // stage 5: rounding with exact errors
   logic v5_ff, zero5_ff;
   logic [COLOR_W-1:0] col5_ff;
   round_type rq5_ff, rr5_ff, rs5_ff;

   // stage 6: repair of worst coordinate, index difference
   logic v6_ff, zero6_ff;
   logic [COLOR_W-1:0] col6_ff;
   logic [17:0] dmag6_ff;
   logic dneg6_ff;
   logic signed [19:0] rq_fix, rr_fix, dsum;

   always_comb begin
      rq_fix = 20'(rq5_ff.rnd);
      rr_fix = 20'(rr5_ff.rnd);
      // q repaired only when its error is strictly largest; else r if above s
      if (rq5_ff.err > rr5_ff.err && rq5_ff.err > rs5_ff.err) begin
         rq_fix = -20'(rs5_ff.rnd) - 20'(rr5_ff.rnd);
      end else if (rr5_ff.err > rs5_ff.err) begin
         rr_fix = -20'(rq5_ff.rnd) - 20'(rs5_ff.rnd);
      end
      dsum = rq_fix - rr_fix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= vq_out;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q4_ff <= q_w;
         r4_ff <= r_w;
         s4_ff <= -q_w - r_w;
         zero4_ff <= side_q[COLOR_W];
         col4_ff <= side_q[COLOR_W-1:0];
         rq5_ff <= htci_round(q4_ff);
         rr5_ff <= htci_round(r4_ff);
         rs5_ff <= htci_round(s4_ff);
         zero5_ff <= zero4_ff;
         col5_ff <= col4_ff;
         dneg6_ff <= dsum[19];
         dmag6_ff <= dsum[19] ? 18'(-dsum) : 18'(dsum);
         zero6_ff <= zero5_ff;
         col6_ff <= col5_ff;
      end
   end

   // index magnitude mod colors
   logic vm_out;
   logic [COLOR_W-1:0] rem_m;
   logic [COLOR_W+1:0] side_m;

   htci_div #(.NUM_W(18), .DEN_W(COLOR_W), .SIDE_W(COLOR_W + 2)) u_div_mod (
      .clock(clock), .reset(reset), .en(en), .in_valid(v6_ff),
      .num(dmag6_ff), .den(col6_ff), .side({dneg6_ff, zero6_ff, col6_ff}),
      .out_valid(vm_out), .quo(), .rem(rem_m), .side_out(side_m)
   );

   // stage 7: non-negative index, scaled numerator
   logic v7_ff, zero7_ff;
   logic [COLOR_W-1:0] idx7_ff, den7_ff;
   logic [COLOR_W-1:0] idx_w, col_m;

   assign col_m = side_m[COLOR_W-1:0];
   assign idx_w = (side_m[COLOR_W+1] && rem_m != '0) ? col_m - rem_m : rem_m;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= vm_out;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx7_ff <= idx_w;
         den7_ff <= col_m - 8'd1;
         zero7_ff <= side_m[COLOR_W];
      end
   end

   logic [23:0] lvl_num;
   assign lvl_num = 24'({idx7_ff, 16'h0000}) - 24'(idx7_ff);

   // level = index * 65535 / (colors - 1)
   logic vl_out, zero_l;
   logic [23:0] quo_l;

   htci_div #(.NUM_W(24), .DEN_W(COLOR_W), .SIDE_W(1)) u_div_lvl (
      .clock(clock), .reset(reset), .en(en), .in_valid(v7_ff),
      .num(lvl_num), .den(den7_ff), .side(zero7_ff),
      .out_valid(vl_out), .quo(quo_l), .rem(), .side_out(zero_l)
   );

   // output register
   logic [LEVEL_W-1:0] level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vl_out;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         level_ff <= zero_l ? '0 : quo_l[LEVEL_W-1:0];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.level = level_ff;

   `HTCI_ASSERT_SAME(a_div_lockstep, clock, reset, 1'b1, vq_out == vr_out)
   `HTCI_ASSERT_SAME(a_idx_range, clock, reset, v7_ff, idx7_ff < den7_ff + 8'd1)
   `HTCI_ASSERT_SAME(a_level_fits, clock, reset, vl_out, quo_l[23:16] == 8'd0)
   `HTCI_ASSERT_NEXT(a_out_load, clock, reset, en && vl_out, rsp_valid_ff)
endmodule
